// ----- sv/npn_pkg.sv -----
package npn_pkg;

  localparam int TT_W       = 16;
  localparam int N_W        = 3;
  localparam int SLOT_W     = 2;
  localparam int NUM_SLOTS  = 4;
  localparam int NUM_PERMS  = 24;
  localparam int PERM_IDX_W = 5;

  localparam logic [PERM_IDX_W-1:0] LAST_PERM = PERM_IDX_W'(NUM_PERMS - 1);

  typedef logic [NUM_SLOTS-1:0][SLOT_W-1:0] perm_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FINISH
  } npn_state_t;

  typedef struct packed {
    logic start;
    logic step;
    logic publish;
  } npn_cmd_t;

  // Permutations of four slots in lexicographic order; hex digit j (from the
  // left) is the new position of input j.
  localparam logic [15:0] PERM_CODES [NUM_PERMS] = '{
    16'h0123, 16'h0132, 16'h0213, 16'h0231, 16'h0312, 16'h0321,
    16'h1023, 16'h1032, 16'h1203, 16'h1230, 16'h1302, 16'h1320,
    16'h2013, 16'h2031, 16'h2103, 16'h2130, 16'h2301, 16'h2310,
    16'h3012, 16'h3021, 16'h3102, 16'h3120, 16'h3201, 16'h3210
  };

  function automatic perm_t perm_at(input logic [PERM_IDX_W-1:0] idx);
    logic [15:0] code;
    perm_t       p;
    code = PERM_CODES[idx];
    for (int j = 0; j < NUM_SLOTS; j++) begin
      p[j] = code[13-4*j -: SLOT_W];
    end
    return p;
  endfunction

  // Bits of the truth table that exist for n inputs.
  function automatic logic [TT_W-1:0] omask_of(input logic [N_W-1:0] n);
    logic [TT_W-1:0] m;
    for (int i = 0; i < TT_W; i++) begin
      m[i] = (5'(i) < (5'd1 << n));
    end
    return m;
  endfunction

endpackage

// ----- sv/npn_ctrl.sv -----
module npn_ctrl
  import npn_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     out_stall,
  input  logic     last,
  output npn_cmd_t cmd,
  output logic     in_stall,
  output logic     out_valid
);

  npn_state_t state, state_next;
  logic       out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (last) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid || !out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.start   = (state == ST_IDLE) && in_valid;
    cmd.step    = (state == ST_SEARCH);
    cmd.publish = (state == ST_FINISH) && (!out_valid || !out_stall);
    in_stall    = (state != ST_IDLE);
    // The result register frees once its beat is taken.
    out_valid_next = cmd.publish || (out_valid && out_stall);
  end

endmodule

// ----- sv/npn_dp.sv -----
module npn_dp
  import npn_pkg::*;
#(
  parameter int NEG_W = 4
) (
  input  logic              clk,
  input  npn_cmd_t          cmd,
  input  logic [N_W-1:0]    n,
  input  logic [TT_W-1:0]   truth_table,
  output logic              last,
  output logic [TT_W-1:0]   canonical_table,
  output logic [3:0]        input_negation,
  output logic              output_negation,
  output perm_t             perm_out
);

  logic [TT_W-1:0]       tt;
  logic [PERM_IDX_W-1:0] perm_idx;
  logic [NEG_W-1:0]      neg;
  logic                  have;
  logic [TT_W-1:0]       best;
  logic [NEG_W-1:0]      best_neg;
  logic                  best_onv;
  perm_t                 best_perm;

  logic [TT_W-1:0]  omask;
  logic [NEG_W-1:0] neg_max;
  perm_t            perm;
  perm_t            perm_masked;
  logic             perm_valid;
  logic [TT_W-1:0]  cand;
  logic [TT_W-1:0]  inv;
  logic [TT_W-1:0]  mid;
  logic             take_c;
  logic             take_i;

  function automatic logic [TT_W-1:0] xform(input logic [TT_W-1:0] f, input perm_t p,
                                            input logic [3:0] ng,
                                            input logic [TT_W-1:0] om);
    logic [TT_W-1:0] res;
    logic [3:0]      iv;
    logic [3:0]      dst;
    res = '0;
    for (int i = 0; i < TT_W; i++) begin
      iv  = 4'(i);
      dst = '0;
      for (int j = 0; j < NUM_SLOTS; j++) begin
        if (iv[j]) dst[p[j]] = 1'b1;
      end
      if (om[i] && f[iv ^ ng]) res[dst] = 1'b1;
    end
    return res;
  endfunction

  always_comb begin
    omask   = omask_of(n);
    neg_max = NEG_W'((5'd1 << n) - 5'd1);
    perm    = perm_at(perm_idx);
    // A permutation belongs to the n-input sweep only if it leaves the
    // unused slots in place.
    perm_valid = 1'b1;
    for (int j = 0; j < NUM_SLOTS; j++) begin
      if (3'(j) >= n) begin
        if (perm[j] != SLOT_W'(j)) perm_valid = 1'b0;
        perm_masked[j] = '0;
      end else begin
        perm_masked[j] = perm[j];
      end
    end
    cand   = xform(tt, perm, 4'(neg), omask);
    inv    = cand ^ omask;
    take_c = !have || (cand > best);
    mid    = take_c ? cand : best;
    take_i = (inv > mid);
    last   = (perm_idx == LAST_PERM) && (!perm_valid || (neg == neg_max));
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      tt       <= truth_table & omask;
      perm_idx <= '0;
      neg      <= '0;
      have     <= 1'b0;
    end else if (cmd.step) begin
      if (!perm_valid || (neg == neg_max)) begin
        perm_idx <= perm_idx + PERM_IDX_W'(1);
        neg      <= '0;
      end else begin
        neg <= neg + NEG_W'(1);
      end
      if (perm_valid) begin
        have <= 1'b1;
        if (take_c || take_i) begin
          best      <= take_i ? inv : cand;
          best_neg  <= neg;
          best_onv  <= take_i;
          best_perm <= perm_masked;
        end
      end
    end
    if (cmd.publish) begin
      canonical_table <= best;
      input_negation  <= 4'(best_neg);
      output_negation <= best_onv;
      perm_out        <= best_perm;
    end
  end

endmodule

// ----- sv/npn_canonical_form.sv -----
// NPN canonical form search over up to four inputs.
// A beat is taken in ST_IDLE; ST_SEARCH sweeps the permutations and, for each
// valid one, the input negation masks; ST_FINISH loads the result register
// once out_stall does not hold the last one, then out_valid rises. No new table
// is taken till then; one transform unit scores a permutation and mask per cycle.
// Reset: synchronous, clears the controller and result valid; num_inputs returns to 4.
module npn_canonical_form
  import npn_pkg::*;
#(
  parameter int MAX_INPUTS = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [N_W-1:0]    cfg_num_inputs,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [TT_W-1:0]   truth_table,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [TT_W-1:0]   canonical_table,
  output logic [3:0]        input_negation,
  output logic              output_negation,
  output logic [SLOT_W-1:0] perm_slot0,
  output logic [SLOT_W-1:0] perm_slot1,
  output logic [SLOT_W-1:0] perm_slot2,
  output logic [SLOT_W-1:0] perm_slot3
);

  localparam logic [N_W-1:0] MAX_N = N_W'(MAX_INPUTS);

  logic [N_W-1:0] num_inputs;
  logic [N_W-1:0] n_eff;
  npn_cmd_t       cmd;
  logic           last;
  perm_t          perm_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_inputs <= N_W'(4);
    end else if (cfg_valid && cfg_ready) begin
      num_inputs <= cfg_num_inputs;
    end
  end

  always_comb begin
    if (num_inputs == '0) n_eff = N_W'(1);
    else if (num_inputs > MAX_N) n_eff = MAX_N;
    else n_eff = num_inputs;
  end

  npn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .last      (last),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  npn_dp #(
    .NEG_W (MAX_INPUTS)
  ) u_dp (
    .clk             (clk),
    .cmd             (cmd),
    .n               (n_eff),
    .truth_table     (truth_table),
    .last            (last),
    .canonical_table (canonical_table),
    .input_negation  (input_negation),
    .output_negation (output_negation),
    .perm_out        (perm_out)
  );

  assign perm_slot0 = perm_out[0];
  assign perm_slot1 = perm_out[1];
  assign perm_slot2 = perm_out[2];
  assign perm_slot3 = perm_out[3];

  // Once a beat is taken the block stays busy until its result is published.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again right after an accept");

  // The winner can never be beaten by its own complement.
  a_max_polarity: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (canonical_table >= (canonical_table ^ omask_of(n_eff))))
    else $error("canonical table smaller than its complement");

  a_unused_bits: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((canonical_table & ~omask_of(n_eff)) == '0))
    else $error("canonical table has bits beyond the used minterms");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import npn_pkg::*;

  typedef struct packed {
    logic [TT_W-1:0]   canon;
    logic [3:0]        neg_mask;
    logic              inverted;
    logic [SLOT_W-1:0] s0;
    logic [SLOT_W-1:0] s1;
    logic [SLOT_W-1:0] s2;
    logic [SLOT_W-1:0] s3;
  } npn_result_t;

  typedef struct packed {
    logic [N_W-1:0]  setting;
    logic [TT_W-1:0] tt;
    logic            typed;
    npn_result_t     want;
  } corner_row_t;

  localparam int NUM_CORNERS    = 25;
  localparam int NUM_PHASES     = 10;
  localparam int TABLES_PER_PHASE = 75;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 400;

  // Input counts for the random phases: the extremes, the out-of-range codes and the rest.
  localparam logic [N_W-1:0] PHASE_SETTINGS [NUM_PHASES] = '{
    3'd4, 3'd1, 3'd2, 3'd3, 3'd0, 3'd7, 3'd5, 3'd6, 3'd2, 3'd4
  };

  // Rows whose answer is obvious carry it; the others are scored by the search below.
  localparam corner_row_t CORNERS [NUM_CORNERS] = '{
    '{3'd4, 16'h0000, 1'b1, '{16'hFFFF, 4'h0, 1'b1, 2'd0, 2'd1, 2'd2, 2'd3}},
    '{3'd4, 16'hFFFF, 1'b1, '{16'hFFFF, 4'h0, 1'b0, 2'd0, 2'd1, 2'd2, 2'd3}},
    '{3'd4, 16'h8000, 1'b0, '0},
    '{3'd4, 16'h0001, 1'b0, '0},
    '{3'd4, 16'h6996, 1'b0, '0},
    '{3'd4, 16'h8001, 1'b0, '0},
    '{3'd4, 16'hAAAA, 1'b0, '0},
    '{3'd4, 16'h1234, 1'b0, '0},
    '{3'd1, 16'h0000, 1'b1, '{16'h0003, 4'h0, 1'b1, 2'd0, 2'd0, 2'd0, 2'd0}},
    '{3'd1, 16'h0003, 1'b1, '{16'h0003, 4'h0, 1'b0, 2'd0, 2'd0, 2'd0, 2'd0}},
    '{3'd1, 16'hFFFC, 1'b1, '{16'h0003, 4'h0, 1'b1, 2'd0, 2'd0, 2'd0, 2'd0}},
    '{3'd1, 16'h0001, 1'b0, '0},
    '{3'd1, 16'h0002, 1'b0, '0},
    '{3'd0, 16'h0002, 1'b0, '0},
    '{3'd0, 16'hFFFE, 1'b0, '0},
    '{3'd2, 16'hFFF0, 1'b1, '{16'h000F, 4'h0, 1'b1, 2'd0, 2'd1, 2'd0, 2'd0}},
    '{3'd2, 16'h0008, 1'b0, '0},
    '{3'd2, 16'h0006, 1'b0, '0},
    '{3'd3, 16'h0080, 1'b0, '0},
    '{3'd3, 16'h0096, 1'b0, '0},
    '{3'd3, 16'hFF00, 1'b1, '{16'h00FF, 4'h0, 1'b1, 2'd0, 2'd1, 2'd2, 2'd0}},
    '{3'd7, 16'hFFFF, 1'b1, '{16'hFFFF, 4'h0, 1'b0, 2'd0, 2'd1, 2'd2, 2'd3}},
    '{3'd7, 16'h1234, 1'b0, '0},
    '{3'd5, 16'h0001, 1'b0, '0},
    '{3'd6, 16'hFFFE, 1'b0, '0}
  };

  logic              clk;
  logic              rst;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [N_W-1:0]    cfg_num_inputs;
  logic              in_valid;
  logic              in_stall;
  logic [TT_W-1:0]   truth_table;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [TT_W-1:0]   canonical_table;
  logic [3:0]        input_negation;
  logic              output_negation;
  logic [SLOT_W-1:0] perm_slot0;
  logic [SLOT_W-1:0] perm_slot1;
  logic [SLOT_W-1:0] perm_slot2;
  logic [SLOT_W-1:0] perm_slot3;

  npn_result_t    pending_canon [$];
  logic [N_W-1:0] model_setting = 3'd4;
  bit             idle_on = 1'b1;
  int             tables_sent = 0;
  int             results_checked = 0;
  int             settings_written = 0;
  int             errors = 0;
  int             quiet_cycles = 0;
  int             stall_left = 0;

  npn_canonical_form #(
    .MAX_INPUTS(4)
  ) uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_num_inputs (cfg_num_inputs),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .truth_table    (truth_table),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .canonical_table(canonical_table),
    .input_negation (input_negation),
    .output_negation(output_negation),
    .perm_slot0     (perm_slot0),
    .perm_slot1     (perm_slot1),
    .perm_slot2     (perm_slot2),
    .perm_slot3     (perm_slot3)
  );

  always #10 clk = ~clk;

  // Exhaustive search for the largest table under input permutation, input negation and
  // output negation. Permutations are walked as four base-4 digits, input 0 most
  // significant, so ascending codes visit them in lexicographic order.
  function automatic npn_result_t canonicalise(input logic [TT_W-1:0] tt_in,
                                              input logic [N_W-1:0] setting);
    npn_result_t       best;
    logic [TT_W-1:0]   mask;
    logic [TT_W-1:0]   tt;
    logic [TT_W-1:0]   cand;
    logic [TT_W-1:0]   pick;
    logic [SLOT_W-1:0] slot [4];
    int                n;
    int                rows;
    int                dst;
    bit                have;
    bit                legal;
    best = '0;
    have = 1'b0;
    n = (setting == 0) ? 1 : (setting > 4) ? 4 : int'(setting);
    rows = 1 << n;
    mask = '0;
    for (int k = 0; k < rows; k++) mask[k] = 1'b1;
    tt = tt_in & mask;
    for (int code = 0; code < 256; code++) begin
      legal = 1'b1;
      for (int j = 0; j < 4; j++) begin
        slot[j] = SLOT_W'((code >> (6 - 2 * j)) & 3);
        if (j >= n) begin
          if (slot[j] != 0) legal = 1'b0;
        end else begin
          if (slot[j] >= n) legal = 1'b0;
          for (int k = 0; k < j; k++) begin
            if (slot[k] == slot[j]) legal = 1'b0;
          end
        end
      end
      if (legal) begin
        for (int neg = 0; neg < rows; neg++) begin
          cand = '0;
          for (int i = 0; i < rows; i++) begin
            if (tt[(i ^ neg) & 15]) begin
              dst = 0;
              for (int j = 0; j < n; j++) begin
                if (i[j]) dst = dst | (1 << slot[j]);
              end
              cand[dst] = 1'b1;
            end
          end
          // The plain output is scored before the inverted one; ties keep the earlier.
          for (int pol = 0; pol < 2; pol++) begin
            pick = (pol == 1) ? (cand ^ mask) : cand;
            if (!have || pick > best.canon) begin
              have = 1'b1;
              best.canon = pick;
              best.neg_mask = 4'(neg);
              best.inverted = (pol == 1);
              best.s0 = slot[0];
              best.s1 = slot[1];
              best.s2 = slot[2];
              best.s3 = slot[3];
            end
          end
        end
      end
    end
    return best;
  endfunction

  task automatic wait_drained();
    while (pending_canon.size() != 0) @(posedge clk);
  endtask

  // Entered and left just after a falling edge.
  task automatic write_setting(input logic [N_W-1:0] value);
    in_valid <= 1'b0;
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_num_inputs <= value;
    do @(posedge clk); while (!cfg_ready);
    model_setting = value;
    settings_written++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_num_inputs <= N_W'($urandom_range(0, 7));
  endtask

  // Entered and left just after a falling edge.
  task automatic push_table(input logic [TT_W-1:0] tt, input bit typed,
                            input npn_result_t want);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      truth_table <= TT_W'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    truth_table <= tt;
    do @(posedge clk); while (in_stall);
    pending_canon.insert(pending_canon.size(),
                         typed ? want : canonicalise(tt, model_setting));
    tables_sent++;
    @(negedge clk);
  endtask

  function automatic logic [TT_W-1:0] random_table();
    case ($urandom_range(0, 7))
      0: return TT_W'(1) << $urandom_range(0, 15);
      1: return ~(TT_W'(1) << $urandom_range(0, 15));
      2: return $urandom_range(0, 1) ? '1 : '0;
      default: return TT_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Receiver back-pressure in short bursts.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic check_field(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      errors++;
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    npn_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_canon.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing outstanding, expected none, got table 0x%0h",
                 $time, canonical_table);
      end else begin
        want = pending_canon.pop_front();
        results_checked++;
        check_field("canonical_table", want.canon, canonical_table);
        check_field("input_negation", want.neg_mask, input_negation);
        check_field("output_negation", want.inverted, output_negation);
        check_field("perm_slot0", want.s0, perm_slot0);
        check_field("perm_slot1", want.s1, perm_slot1);
        check_field("perm_slot2", want.s2, perm_slot2);
        check_field("perm_slot3", want.s3, perm_slot3);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timed out after %0d cycles without a beat.", quiet_cycles);
      $display("npn_canonical_form: mismatch");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_num_inputs = '0;
    in_valid = 1'b0;
    truth_table = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int r = 0; r < NUM_CORNERS; r++) begin
      if (r == 0 || CORNERS[r].setting != CORNERS[r-1].setting) begin
        write_setting(CORNERS[r].setting);
      end
      push_table(CORNERS[r].tt, CORNERS[r].typed, CORNERS[r].want);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      // The closing phase runs with both sides flat out.
      if (p == NUM_PHASES - 1) idle_on = 1'b0;
      write_setting(PHASE_SETTINGS[p]);
      for (int t = 0; t < TABLES_PER_PHASE; t++) begin
        push_table(random_table(), 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d truth tables across %0d input-count writes; %0d results checked.",
             tables_sent, settings_written, results_checked);
    if (errors == 0) begin
      $display("npn_canonical_form: match");
    end else begin
      $display("%0d field mismatches.", errors);
      $display("npn_canonical_form: mismatch");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/npn_pkg.sv
sv/npn_ctrl.sv
sv/npn_dp.sv
sv/npn_canonical_form.sv
tb/testbench.sv
